[rtl/vrt_pkg.sv]
// Shared constants, codes and control types for the voxel ray traversal block.
package vrt_pkg;
   localparam int GRID_X    = 64;
   localparam int GRID_Y    = 64;
   localparam int GRID_Z    = 64;
   localparam int MAP_CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W    = $clog2(MAP_CELLS);
   localparam int CELL_W    = 12;
   localparam int MAG_W     = 16;
   localparam int Q_W       = 23;
   localparam int T_W       = 24;
   localparam int DIST_W    = 9;
   localparam int JOBS      = 6;

   typedef enum logic [1:0] {
      ST_WRITE = 2'd0,
      ST_HIT   = 2'd1,
      ST_LEFT  = 2'd2,
      ST_NOHIT = 2'd3
   } status_type;

   typedef struct packed {
      logic       clr;
      logic       load;
      logic       wr;
      logic       div_init;
      logic       div_iter;
      logic       div_save;
      logic       rd;
      logic       adv;
      logic       out;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic job_last;
      logic in_grid;
      logic solid;
      logic limit_hit;
      logic rsp_busy;
   } stat_type;
endpackage

[rtl/voxel_ray_traversal.sv]
// Top level of the voxel ray traversal block.
// After reset the block clears its 64x64x64 solid map, one voxel per cycle,
// holding req_stall high. A write item passes through the write state and the
// result load before the next item can be accepted. A cast item runs setup (six
// 23-bit quotients from one shared restoring divider), then a map read and a
// check and step for each voxel examined, then loads the result register. A new
// item is accepted while the previous result still waits on rsp_stall.
module voxel_ray_traversal import vrt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic signed [14:0] req_pos_x,
   input  logic signed [14:0] req_pos_y,
   input  logic signed [14:0] req_pos_z,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic signed [15:0] req_dir_z,
   input  logic [15:0]        req_max_dist,
   input  logic               req_solid_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [7:0]  rsp_end_x,
   output logic signed [7:0]  rsp_end_y,
   output logic signed [7:0]  rsp_end_z,
   output logic signed [1:0]  rsp_normal_x,
   output logic signed [1:0]  rsp_normal_y,
   output logic signed [1:0]  rsp_normal_z
);
   cmd_type  cmd;
   stat_type stat;

   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   vrt_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .req_max_dist    (req_max_dist),
      .req_solid_value (req_solid_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_end_x       (rsp_end_x),
      .rsp_end_y       (rsp_end_y),
      .rsp_end_z       (rsp_end_z),
      .rsp_normal_x    (rsp_normal_x),
      .rsp_normal_y    (rsp_normal_y),
      .rsp_normal_z    (rsp_normal_z)
   );
endmodule

[rtl/vrt_datapath.sv]
// Datapath: solid map memory, per-axis DDA registers, shared divider and result register.
module vrt_datapath import vrt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic signed [14:0]       req_pos_x,
   input  logic signed [14:0]       req_pos_y,
   input  logic signed [14:0]       req_pos_z,
   input  logic signed [15:0]       req_dir_x,
   input  logic signed [15:0]       req_dir_y,
   input  logic signed [15:0]       req_dir_z,
   input  logic [15:0]              req_max_dist,
   input  logic                     req_solid_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [7:0]        rsp_end_x,
   output logic signed [7:0]        rsp_end_y,
   output logic signed [7:0]        rsp_end_z,
   output logic signed [1:0]        rsp_normal_x,
   output logic signed [1:0]        rsp_normal_y,
   output logic signed [1:0]        rsp_normal_z
);
   localparam logic signed [CELL_W-1:0] GX_C = CELL_W'(GRID_X);
   localparam logic signed [CELL_W-1:0] GY_C = CELL_W'(GRID_Y);
   localparam logic signed [CELL_W-1:0] GZ_C = CELL_W'(GRID_Z);

   logic                     mem [0:MAP_CELLS-1];
   logic                     rd_ff;
   logic [ADDR_W-1:0]        clr_ff;

   logic [15:0]              limit_ff;
   logic                     solid_ff;
   logic signed [CELL_W-1:0] cell_ff [0:2];
   logic [T_W-1:0]           tnext_ff [0:2];
   logic [Q_W-1:0]           tdelta_ff [0:2];
   logic                     moving_ff [0:2];
   logic                     neg_ff [0:2];
   logic [MAG_W-1:0]         mag_ff [0:2];
   logic [DIST_W-1:0]        dist_ff [0:2];
   logic [1:0]               last_ff;

   logic [2:0]               job_ff;
   logic [4:0]               cnt_ff;
   logic [Q_W-1:0]           sh_ff;
   logic [MAG_W-1:0]         rem_ff;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic signed [7:0]        end_ff [0:2];
   logic signed [1:0]        nrm_ff [0:2];

   logic signed [14:0]       pos_in [0:2];
   logic signed [15:0]       dir_in [0:2];
   logic [1:0]               div_axis;
   logic [MAG_W:0]           trial;
   logic                     ge;
   logic                     e01, e02, e12;
   logic [1:0]               sel;
   logic                     in_grid;
   logic [ADDR_W-1:0]        addr;

   assign pos_in[0] = req_pos_x;
   assign pos_in[1] = req_pos_y;
   assign pos_in[2] = req_pos_z;
   assign dir_in[0] = req_dir_x;
   assign dir_in[1] = req_dir_y;
   assign dir_in[2] = req_dir_z;

   function automatic logic earlier(input logic ma, input logic mb,
                                    input logic [T_W-1:0] ta, input logic [T_W-1:0] tb);
      earlier = ma && (!mb || ta < tb);
   endfunction

   always_comb begin
      e01 = earlier(moving_ff[0], moving_ff[1], tnext_ff[0], tnext_ff[1]);
      e02 = earlier(moving_ff[0], moving_ff[2], tnext_ff[0], tnext_ff[2]);
      e12 = earlier(moving_ff[1], moving_ff[2], tnext_ff[1], tnext_ff[2]);
      if (e01) begin
         sel = e02 ? 2'd0 : 2'd2;
      end else begin
         sel = e12 ? 2'd1 : 2'd2;
      end
   end

   assign in_grid = !cell_ff[0][CELL_W-1] && cell_ff[0] < GX_C
                 && !cell_ff[1][CELL_W-1] && cell_ff[1] < GY_C
                 && !cell_ff[2][CELL_W-1] && cell_ff[2] < GZ_C;
   assign addr = ADDR_W'($unsigned(cell_ff[0])) + ADDR_W'(GRID_X) *
                 (ADDR_W'($unsigned(cell_ff[1])) + ADDR_W'(GRID_Y) *
                  ADDR_W'($unsigned(cell_ff[2])));

   assign div_axis = job_ff[2:1];
   assign trial    = {rem_ff, sh_ff[Q_W-1]};
   assign ge       = trial >= {1'b0, mag_ff[div_axis]};

   assign stat.clr_last  = clr_ff == ADDR_W'(MAP_CELLS - 1);
   assign stat.div_last  = cnt_ff == 5'(Q_W - 1);
   assign stat.job_last  = job_ff == 3'(JOBS - 1);
   assign stat.in_grid   = in_grid;
   assign stat.solid     = rd_ff;
   assign stat.limit_hit = !moving_ff[sel] || tnext_ff[sel] > T_W'(limit_ff);
   assign stat.rsp_busy  = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         mem[clr_ff] <= 1'b0;
      end else if (cmd.wr && in_grid) begin
         mem[addr] <= solid_ff;
      end
      if (cmd.rd) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         limit_ff <= req_max_dist;
         solid_ff <= req_solid_value;
         last_ff  <= 2'd3;
         job_ff   <= '0;
         for (int i = 0; i < 3; i++) begin
            cell_ff[i]   <= CELL_W'(signed'(pos_in[i][14:8]));
            moving_ff[i] <= dir_in[i] != '0;
            neg_ff[i]    <= dir_in[i][15] || dir_in[i] == '0;
            mag_ff[i]    <= dir_in[i][15] ? MAG_W'(-dir_in[i]) : MAG_W'(dir_in[i]);
            dist_ff[i]   <= (dir_in[i][15] || dir_in[i] == '0)
                            ? {1'b0, pos_in[i][7:0]}
                            : DIST_W'(256) - {1'b0, pos_in[i][7:0]};
            tnext_ff[i]  <= '0;
            tdelta_ff[i] <= '0;
         end
      end
      if (cmd.div_init) begin
         sh_ff  <= job_ff[0] ? {dist_ff[div_axis], 14'b0} : Q_W'(1) << 22;
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_iter) begin
         rem_ff <= ge ? MAG_W'(trial - {1'b0, mag_ff[div_axis]}) : MAG_W'(trial);
         sh_ff  <= {sh_ff[Q_W-2:0], ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.div_save) begin
         if (job_ff[0]) begin
            tnext_ff[div_axis] <= T_W'(sh_ff);
         end else begin
            tdelta_ff[div_axis] <= sh_ff;
         end
         job_ff <= job_ff + 1'b1;
      end
      if (cmd.adv) begin
         cell_ff[sel]  <= neg_ff[sel] ? cell_ff[sel] - 1'b1 : cell_ff[sel] + 1'b1;
         tnext_ff[sel] <= tnext_ff[sel] + T_W'(tdelta_ff[sel]);
         last_ff       <= sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out) begin
         rsp_status_ff <= cmd.code;
         for (int i = 0; i < 3; i++) begin
            end_ff[i] <= (cmd.code == ST_WRITE) ? 8'sd0 : cell_ff[i][7:0];
            nrm_ff[i] <= (cmd.code != ST_WRITE && last_ff == 2'(i))
                         ? (neg_ff[i] ? 2'sb01 : 2'sb11) : 2'sb00;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_end_x    = end_ff[0];
   assign rsp_end_y    = end_ff[1];
   assign rsp_end_z    = end_ff[2];
   assign rsp_normal_x = nrm_ff[0];
   assign rsp_normal_y = nrm_ff[1];
   assign rsp_normal_z = nrm_ff[2];
endmodule

[rtl/vrt_ctrl.sv]
// Controller: sequences clearing, writes, divider setup, the voxel walk and result load.
module vrt_ctrl import vrt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_type,
   output logic     req_stall,
   output cmd_type  cmd,
   input  stat_type stat
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WRITE, S_DIV_INIT, S_DIV_RUN, S_DIV_SAVE, S_RD, S_CHK, S_OUT
   } state_type;

   state_type  state_ff;
   status_type code_ff;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      cmd          = '0;
      cmd.code     = code_ff;
      cmd.clr      = state_ff == S_CLEAR;
      cmd.load     = state_ff == S_IDLE && req_valid;
      cmd.wr       = state_ff == S_WRITE;
      cmd.div_init = state_ff == S_DIV_INIT;
      cmd.div_iter = state_ff == S_DIV_RUN;
      cmd.div_save = state_ff == S_DIV_SAVE;
      cmd.rd       = state_ff == S_RD;
      cmd.adv      = state_ff == S_CHK && stat.in_grid && !stat.solid && !stat.limit_hit;
      cmd.out      = state_ff == S_OUT && !stat.rsp_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= ST_WRITE;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (stat.clr_last) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) state_ff <= req_type ? S_DIV_INIT : S_WRITE;
            end
            S_WRITE: begin
               code_ff  <= ST_WRITE;
               state_ff <= S_OUT;
            end
            S_DIV_INIT: state_ff <= S_DIV_RUN;
            S_DIV_RUN: begin
               if (stat.div_last) state_ff <= S_DIV_SAVE;
            end
            S_DIV_SAVE: state_ff <= stat.job_last ? S_RD : S_DIV_INIT;
            S_RD: state_ff <= S_CHK;
            S_CHK: begin
               if (!stat.in_grid) begin
                  code_ff  <= ST_LEFT;
                  state_ff <= S_OUT;
               end else if (stat.solid) begin
                  code_ff  <= ST_HIT;
                  state_ff <= S_OUT;
               end else if (stat.limit_hit) begin
                  code_ff  <= ST_NOHIT;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_RD;
               end
            end
            S_OUT: begin
               if (!stat.rsp_busy) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[rtl/vrt_checker.sv]
// Port-level assertions for the voxel ray traversal block, bound to the top level.
module vrt_checker import vrt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_status,
   input logic signed [7:0] rsp_end_x,
   input logic signed [1:0] rsp_normal_x,
   input logic signed [1:0] rsp_normal_y,
   input logic signed [1:0] rsp_normal_z
);
   a_clear_stall: assert property (@(posedge clock) reset |=> req_stall && !rsp_valid)
      else $error("block not stalled during map clear");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled item dropped or changed");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_WRITE |-> rsp_end_x == 8'sd0 && rsp_normal_x == 2'sd0
         && rsp_normal_y == 2'sd0 && rsp_normal_z == 2'sd0)
      else $error("write item carries walk fields");

   a_one_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_normal_x != 2'sd0, rsp_normal_y != 2'sd0,
                                rsp_normal_z != 2'sd0}) <= 1)
      else $error("more than one face normal set");

   a_normal_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x != 2'sb10 && rsp_normal_y != 2'sb10
         && rsp_normal_z != 2'sb10)
      else $error("normal out of range");
endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_end_x    (rsp_end_x),
   .rsp_normal_x (rsp_normal_x),
   .rsp_normal_y (rsp_normal_y),
   .rsp_normal_z (rsp_normal_z)
);
